// File: rtl/vertex_perspective_project_assert.svh
// Assertion macros shared by the checker of the vertex projection block.
`ifndef VERTEX_PERSPECTIVE_PROJECT_ASSERT_SVH
`define VERTEX_PERSPECTIVE_PROJECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vertex projection check failed");

// Consequent must hold in the cycle after the antecedent.
`define VPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vertex projection check failed");

`endif

// File: rtl/vpp_pkg.sv
// Types and constants shared by the vertex projection block.
package vpp_pkg;

	localparam int IMAGE_WIDTH_DEF  = 240;
	localparam int IMAGE_HEIGHT_DEF = 240;

	// Camera offset in Q4.12: y - 0.5 and z - 5.
	localparam int CAM_Y_OFF = 2048;
	localparam int CAM_Z_OFF = 20480;

	// Quotient bits cover 1.5 times the largest image size of 1024.
	localparam int QB = 11;
	// Scaled dividend and divisor widths.
	localparam int RW = 58;
	localparam int DW = 45;

	localparam int IDXW = 3;
	localparam logic [IDXW-1:0] REG_ROT_COS    = 3'd0;
	localparam logic [IDXW-1:0] REG_ROT_SIN    = 3'd1;
	localparam logic [IDXW-1:0] REG_TRANS_X    = 3'd2;
	localparam logic [IDXW-1:0] REG_TRANS_Y    = 3'd3;
	localparam logic [IDXW-1:0] REG_TRANS_Z    = 3'd4;
	localparam logic [IDXW-1:0] REG_PROJ_SCALE = 3'd5;

	localparam logic [15:0] ROT_COS_RST    = 16'h4000;
	localparam logic [15:0] ROT_SIN_RST    = 16'h0000;
	localparam logic [15:0] TRANS_X_RST    = 16'h0000;
	localparam logic [15:0] TRANS_Y_RST    = 16'hE800;
	localparam logic [15:0] TRANS_Z_RST    = 16'h0800;
	localparam logic [15:0] PROJ_SCALE_RST = 16'h1000;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic       visible;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
		logic signed [15:0] trans_x;
		logic signed [15:0] trans_y;
		logic signed [15:0] trans_z;
		logic [15:0]        proj_scale;
	} cfg_t;

	// Word travelling along the divider chain.
	typedef struct packed {
		logic [RW-1:0] rem_x;
		logic [RW-1:0] rem_y;
		logic [DW-1:0] divisor;
		logic [QB-1:0] quo_x;
		logic [QB-1:0] quo_y;
		logic          visible;
		logic          neg_x;
		logic          neg_y;
	} cell_t;

endpackage

// File: rtl/vpp_front.sv
// Transform, projection and clip stages feeding the divider chain.
module vpp_front #(
	parameter int IMAGE_WIDTH  = vpp_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = vpp_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  vpp_pkg::vertex_t in_data,
	input  vpp_pkg::cfg_t    cfg,
	input  logic             dn_adv,
	output logic             adv,
	output logic             out_valid,
	output vpp_pkg::cell_t   out_cell
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [31:0] p_xc_s1, p_zs_s1, p_xs_s1, p_zc_s1;
	logic signed [17:0] y12_s1, y12_s2;
	logic signed [34:0] x26_s2, w_s2, w_s3;
	logic signed [50:0] mx_s3;
	logic signed [34:0] my_s3;
	logic signed [16:0] scale;

	logic signed [52:0] lim, mx_w, my2, w_w, nx, ny;
	logic               vis;
	vpp_pkg::cell_t     cell_d;

	assign adv4 = !v_s4 || dn_adv;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign adv  = adv1;
	assign scale = $signed({1'b0, cfg.proj_scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_xc_s1 <= in_data.vertex_x * cfg.rot_cos;
			p_zs_s1 <= in_data.vertex_z * cfg.rot_sin;
			p_xs_s1 <= in_data.vertex_x * cfg.rot_sin;
			p_zc_s1 <= in_data.vertex_z * cfg.rot_cos;
			y12_s1  <= 18'(in_data.vertex_y) + 18'(cfg.trans_y) - 18'(vpp_pkg::CAM_Y_OFF);
		end
		if (adv2) begin
			x26_s2 <= 35'(p_xc_s1) - 35'(p_zs_s1) + (35'(cfg.trans_x) <<< 14);
			w_s2   <= -(35'(p_xs_s1) + 35'(p_zc_s1)
				+ ((35'(cfg.trans_z) - 35'(vpp_pkg::CAM_Z_OFF)) <<< 14));
			y12_s2 <= y12_s1;
		end
		if (adv3) begin
			mx_s3 <= x26_s2 * scale;
			my_s3 <= y12_s2 * scale;
			w_s3  <= w_s2;
		end
		if (adv4) begin
			out_cell <= cell_d;
		end
	end

	// Clip test against [-2, 2] and the numerators of the two pixel quotients.
	always_comb begin
		mx_w = 53'(mx_s3);
		my2  = 53'(my_s3) <<< 1;
		w_w  = 53'(w_s3);
		lim  = w_w <<< 13;
		vis  = (w_s3 > 0) && (mx_w <= lim) && (mx_w >= -lim) && (my2 <= w_w) && (my2 >= -w_w);
		nx   = mx_w + (w_w <<< 12);
		ny   = (w_w <<< 12) - (53'(my_s3) <<< 14);
		cell_d.rem_x   = vpp_pkg::RW'($unsigned(nx)) * vpp_pkg::RW'(IMAGE_WIDTH);
		cell_d.rem_y   = vpp_pkg::RW'($unsigned(ny)) * vpp_pkg::RW'(IMAGE_HEIGHT);
		cell_d.divisor = vpp_pkg::DW'($unsigned(lim));
		cell_d.quo_x   = '0;
		cell_d.quo_y   = '0;
		cell_d.visible = vis;
		cell_d.neg_x   = nx[52];
		cell_d.neg_y   = ny[52];
	end

	assign out_valid = v_s4;

endmodule

// File: rtl/vpp_div_cell.sv
// One restoring-division cell: settles one quotient bit of both pixel coordinates.
module vpp_div_cell #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  vpp_pkg::cell_t in_cell,
	input  logic           dn_adv,
	output logic           adv,
	output logic           out_valid,
	output vpp_pkg::cell_t out_cell
);

	logic           v_q;
	logic [vpp_pkg::RW-1:0] shifted;
	vpp_pkg::cell_t nxt;

	assign adv     = !v_q || dn_adv;
	assign shifted = vpp_pkg::RW'(in_cell.divisor) << BIT;

	always_comb begin
		nxt = in_cell;
		if (in_cell.rem_x >= shifted) begin
			nxt.rem_x      = in_cell.rem_x - shifted;
			nxt.quo_x[BIT] = 1'b1;
		end
		if (in_cell.rem_y >= shifted) begin
			nxt.rem_y      = in_cell.rem_y - shifted;
			nxt.quo_y[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_cell <= nxt;
	end

	assign out_valid = v_q;

endmodule

// File: rtl/vertex_perspective_project.sv
// Top level of the vertex perspective projection block.
// Each vertex word (x, y, z in signed Q4.12) is rotated about the Y axis by the
// cosine and sine registers, translated, offset by the fixed camera position
// (y - 0.5, z - 5), scaled by the projection scale and divided by w = -z. A vertex
// with w not positive or a projected coordinate outside [-2, 2] comes out with
// visible low and both pixel coordinates zero; otherwise the coordinates are
// mapped to the image and clamped to 0..size-1. The block takes one vertex word
// per clock while vertex_stall is low and returns one pixel word per vertex, in
// order. The pixel word is offered once its vertex word has been accepted and has
// passed sixteen registers: four transform and clip stages, one cell per quotient
// bit in the eleven-cell divider chain, and the output register. The first of
// these loads on the accepting edge. Stages with no word move on, so gaps close
// up while the output is stalled. Configuration writes take effect at once and
// belong only in an idle period.
module vertex_perspective_project #(
	parameter int IMAGE_WIDTH  = vpp_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = vpp_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vertex_valid,
	output logic                       vertex_stall,
	input  vpp_pkg::vertex_t           vertex,
	output logic                       pixel_valid,
	input  logic                       pixel_stall,
	output vpp_pkg::pixel_t            pixel,
	input  logic                       cfg_we,
	input  logic [vpp_pkg::IDXW-1:0]   cfg_index,
	input  logic [15:0]                cfg_data
);

	localparam int QB = vpp_pkg::QB;

	// Configuration registers.
	vpp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos    <= vpp_pkg::ROT_COS_RST;
			cfg_q.rot_sin    <= vpp_pkg::ROT_SIN_RST;
			cfg_q.trans_x    <= vpp_pkg::TRANS_X_RST;
			cfg_q.trans_y    <= vpp_pkg::TRANS_Y_RST;
			cfg_q.trans_z    <= vpp_pkg::TRANS_Z_RST;
			cfg_q.proj_scale <= vpp_pkg::PROJ_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vpp_pkg::REG_ROT_COS:    cfg_q.rot_cos    <= cfg_data;
				vpp_pkg::REG_ROT_SIN:    cfg_q.rot_sin    <= cfg_data;
				vpp_pkg::REG_TRANS_X:    cfg_q.trans_x    <= cfg_data;
				vpp_pkg::REG_TRANS_Y:    cfg_q.trans_y    <= cfg_data;
				vpp_pkg::REG_TRANS_Z:    cfg_q.trans_z    <= cfg_data;
				vpp_pkg::REG_PROJ_SCALE: cfg_q.proj_scale <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Divider chain wiring: slot i feeds cell i, cell i drives slot i+1.
	vpp_pkg::cell_t chain_cell [QB+1];
	logic           chain_valid [QB+1];
	logic           chain_adv [QB+1];
	logic           front_adv;

	vpp_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertex_valid),
		.in_data   (vertex),
		.cfg       (cfg_q),
		.dn_adv    (chain_adv[0]),
		.adv       (front_adv),
		.out_valid (chain_valid[0]),
		.out_cell  (chain_cell[0])
	);

	assign vertex_stall = !front_adv;

	// The most significant quotient bit is settled first.
	for (genvar i = 0; i < QB; i++) begin : g_cell
		vpp_div_cell #(
			.BIT (QB - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_cell   (chain_cell[i]),
			.dn_adv    (chain_adv[i+1]),
			.adv       (chain_adv[i]),
			.out_valid (chain_valid[i+1]),
			.out_cell  (chain_cell[i+1])
		);
	end

	// Output register with clamping of the quotients.
	logic            pixel_valid_q;
	vpp_pkg::pixel_t pixel_q;
	vpp_pkg::pixel_t pixel_d;
	vpp_pkg::cell_t  last;

	assign last          = chain_cell[QB];
	assign chain_adv[QB] = !pixel_valid_q || !pixel_stall;

	always_comb begin
		pixel_d = '0;
		if (last.visible) begin
			pixel_d.visible = 1'b1;
			if (!last.neg_x) begin
				pixel_d.pixel_x = (last.quo_x > QB'(IMAGE_WIDTH - 1))
					? 10'(IMAGE_WIDTH - 1) : 10'(last.quo_x);
			end
			if (!last.neg_y) begin
				pixel_d.pixel_y = (last.quo_y > QB'(IMAGE_HEIGHT - 1))
					? 10'(IMAGE_HEIGHT - 1) : 10'(last.quo_y);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (chain_adv[QB]) begin
			pixel_valid_q <= chain_valid[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_adv[QB]) pixel_q <= pixel_d;
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

endmodule

// File: rtl/vpp_check.sv
// Port checker for the vertex projection block and its bind statement.
`include "vertex_perspective_project_assert.svh"

module vpp_check #(
	parameter int IMAGE_WIDTH  = vpp_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = vpp_pkg::IMAGE_HEIGHT_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            vertex_stall,
	input logic            pixel_valid,
	input logic            pixel_stall,
	input vpp_pkg::pixel_t pixel
);

	logic zero_xy;
	logic in_image;

	assign zero_xy  = (pixel.pixel_x == 10'd0) && (pixel.pixel_y == 10'd0);
	assign in_image = (pixel.pixel_x <= 10'(IMAGE_WIDTH - 1))
		&& (pixel.pixel_y <= 10'(IMAGE_HEIGHT - 1));

	// A stalled word stays offered and unchanged.
	`VPP_ASSERT_NEXT(a_hold_valid, clk, arst_n, pixel_valid && pixel_stall, pixel_valid)
	`VPP_ASSERT_NEXT(a_hold_word, clk, arst_n, pixel_valid && pixel_stall, $stable(pixel))

	// The input only stalls when the whole chain is full behind a stalled output.
	`VPP_ASSERT_NOW(a_stall_cause, clk, arst_n, vertex_stall, pixel_valid && pixel_stall)

	// A clipped vertex carries zero coordinates.
	`VPP_ASSERT_NOW(a_clip_zero, clk, arst_n, pixel_valid && !pixel.visible, zero_xy)

	// Visible pixels stay inside the image.
	`VPP_ASSERT_NOW(a_in_image, clk, arst_n, pixel_valid && pixel.visible, in_image)

endmodule

bind vertex_perspective_project vpp_check #(
	.IMAGE_WIDTH  (IMAGE_WIDTH),
	.IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_vpp_check (.*);

// File: verif/testbench.sv
// Self-checking testbench for the vertex perspective projection block.
`timescale 1ns / 1ps

module testbench;

	localparam int WIDTH_PX  = 240;
	localparam int HEIGHT_PX = 240;
	localparam int LATENCY   = 16;
	localparam int N_RANDOM  = 1850;

	// Register indexes past the end of the list; writes to them are ignored.
	localparam logic [vpp_pkg::IDXW-1:0] REG_PAST_END    = 3'd6;
	localparam logic [vpp_pkg::IDXW-1:0] REG_PAST_END_HI = 3'd7;

	logic                     clk;
	logic                     arst_n;
	logic                     vertex_valid;
	logic                     vertex_stall;
	vpp_pkg::vertex_t         vertex;
	logic                     pixel_valid;
	logic                     pixel_stall;
	vpp_pkg::pixel_t          pixel;
	logic                     cfg_we;
	logic [vpp_pkg::IDXW-1:0] cfg_index;
	logic [15:0]              cfg_data;

	// Local copy of the register file, used by the projection predictor.
	vpp_pkg::cfg_t regs;

	// Pixel words still owed by the block, oldest first.
	vpp_pkg::pixel_t pending_pixels[$];
	int              fail_count;
	bit              hold_off_req;

	vertex_perspective_project #(
		.IMAGE_WIDTH (WIDTH_PX),
		.IMAGE_HEIGHT(HEIGHT_PX)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex      (vertex),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// Floor of num * size / den, clamped to the image; den is always positive.
	function automatic logic [9:0] to_screen(longint num, longint den, longint size);
		longint q;
		if (num < 0)
			return 10'd0;
		q = (num * size) / den;
		if (q > size - 1)
			q = size - 1;
		return q[9:0];
	endfunction

	// Exact projection of one vertex with the current registers.
	function automatic vpp_pkg::pixel_t project_vertex(vpp_pkg::vertex_t v);
		longint vx, vy, vz, c, s, sc, x26, y12, z26, w26, nx, ny, den;
		vpp_pkg::pixel_t p;
		vx = v.vertex_x;
		vy = v.vertex_y;
		vz = v.vertex_z;
		c = regs.rot_cos;
		s = regs.rot_sin;
		sc = longint'({1'b0, regs.proj_scale});
		x26 = vx * c - vz * s + longint'(regs.trans_x) * 16384;
		y12 = vy + longint'(regs.trans_y) - vpp_pkg::CAM_Y_OFF;
		z26 = vx * s + vz * c + (longint'(regs.trans_z) - vpp_pkg::CAM_Z_OFF) * 16384;
		w26 = -z26;
		nx = x26 * sc;
		ny = y12 * sc * 16384;
		den = w26 * 4096;
		p = '0;
		if (w26 <= 0)
			return p;
		if (nx > 2 * den || nx < -2 * den || ny > 2 * den || ny < -2 * den)
			return p;
		p.pixel_x = to_screen(nx + den, 2 * den, WIDTH_PX);
		p.pixel_y = to_screen(den - ny, 2 * den, HEIGHT_PX);
		p.visible = 1'b1;
		return p;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	task automatic write_reg(logic [vpp_pkg::IDXW-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vpp_pkg::REG_ROT_COS:    regs.rot_cos = val;
			vpp_pkg::REG_ROT_SIN:    regs.rot_sin = val;
			vpp_pkg::REG_TRANS_X:    regs.trans_x = val;
			vpp_pkg::REG_TRANS_Y:    regs.trans_y = val;
			vpp_pkg::REG_TRANS_Z:    regs.trans_z = val;
			vpp_pkg::REG_PROJ_SCALE: regs.proj_scale = val;
			default: ;
		endcase
	endtask

	// Waits until every owed word is back and the pipeline has drained.
	task automatic wait_idle();
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Offers one vertex word and holds it until the block takes it.
	// The expected pixel of every word is taken from the predictor and queued;
	// a typed-in expectation, where present, is compared with it before sending.
	task automatic send_vertex(vpp_pkg::vertex_t v);
		pending_pixels.push_back(project_vertex(v));
		vertex <= v;
		vertex_valid <= 1'b1;
		@(posedge clk);
		while (vertex_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_with_gap(vpp_pkg::vertex_t v);
		int g;
		send_vertex(v);
		g = gap_length();
		if (g != 0) begin
			vertex_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Random vertex: mostly small coordinates in front of the camera, some anything.
	function automatic vpp_pkg::vertex_t random_vertex();
		vpp_pkg::vertex_t v;
		if ($urandom_range(0, 3) == 0) begin
			v.vertex_x = 16'($urandom);
			v.vertex_y = 16'($urandom);
			v.vertex_z = 16'($urandom);
		end else begin
			v.vertex_x = 16'($urandom_range(0, 16383) - 8192);
			v.vertex_y = 16'($urandom_range(0, 16383) - 8192);
			v.vertex_z = 16'($urandom_range(0, 16383) - 8192);
		end
		return v;
	endfunction

	// Directed stimulus with typed-in results where they follow at once.
	typedef struct {
		vpp_pkg::vertex_t v;
		bit               known;
		vpp_pkg::pixel_t  p;
	} vec_row_t;

	vec_row_t directed[$];

	// Output side: random stall, one long hold-off on request, and checking.
	initial begin
		int hold;
		pixel_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pixel_stall <= 1'b1;
				repeat (60) @(negedge clk);
			end
			hold = gap_length();
			if (hold != 0) begin
				pixel_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end else begin
				pixel_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		vpp_pkg::pixel_t want;
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel word with none expected: %p", pixel);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel.pixel_x !== want.pixel_x) begin
					$error("pixel_x expected %0d actual %0d", want.pixel_x, pixel.pixel_x);
					fail_count++;
				end
				if (pixel.pixel_y !== want.pixel_y) begin
					$error("pixel_y expected %0d actual %0d", want.pixel_y, pixel.pixel_y);
					fail_count++;
				end
				if (pixel.visible !== want.visible) begin
					$error("visible expected %0d actual %0d", want.visible, pixel.visible);
					fail_count++;
				end
			end
		end
	end

	function automatic vec_row_t row(int x, int y, int z, bit k, int px, int py, bit vis);
		vec_row_t r;
		r.v.vertex_x = 16'(x);
		r.v.vertex_y = 16'(y);
		r.v.vertex_z = 16'(z);
		r.known = k;
		r.p.pixel_x = 10'(px);
		r.p.pixel_y = 10'(py);
		r.p.visible = vis;
		return r;
	endfunction

	initial begin
		int n;
		vpp_pkg::pixel_t calc;
		clk = 1'b0;
		arst_n = 1'b0;
		vertex_valid = 1'b0;
		vertex = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		hold_off_req = 1'b0;
		regs.rot_cos = vpp_pkg::ROT_COS_RST;
		regs.rot_sin = vpp_pkg::ROT_SIN_RST;
		regs.trans_x = vpp_pkg::TRANS_X_RST;
		regs.trans_y = vpp_pkg::TRANS_Y_RST;
		regs.trans_z = vpp_pkg::TRANS_Z_RST;
		regs.proj_scale = vpp_pkg::PROJ_SCALE_RST;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset: origin sits at y -2, z -4.5; visible, centre column.
		directed.push_back(row(0, 0, 0, 1, 120, 173, 1));
		// Vertex at or behind the camera: w not positive, so invisible.
		directed.push_back(row(0, 0, 18432, 1, 0, 0, 0));
		directed.push_back(row(0, 0, 32767, 1, 0, 0, 0));
		// Inside the clip window but beyond the image in x: clamped to the edge columns.
		directed.push_back(row(32767, 0, 0, 1, 239, 173, 1));
		directed.push_back(row(-32768, 0, 0, 1, 0, 173, 1));
		// Extremes of every field, to the predictor.
		directed.push_back(row(-32768, -32768, -32768, 0, 0, 0, 0));
		directed.push_back(row(32767, 32767, -32768, 0, 0, 0, 0));
		directed.push_back(row(-32768, 32767, -32768, 0, 0, 0, 0));
		directed.push_back(row(32767, -32768, -32768, 0, 0, 0, 0));
		// Right on the image edges and just past them, where clamping applies.
		directed.push_back(row(18432, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(18433, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(-18432, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 32767, 0, 0, 0, 0, 0));
		directed.push_back(row(0, -26624, -4096, 0, 0, 0, 0));
		directed.push_back(row(9216, 9216, 0, 0, 0, 0, 0));
		directed.push_back(row(-4096, 4096, -30000, 0, 0, 0, 0));
		foreach (directed[i]) begin
			if (directed[i].known) begin
				calc = project_vertex(directed[i].v);
				if (calc !== directed[i].p) begin
					$error("directed row %0d: predictor %p table %p", i, calc, directed[i].p);
					fail_count++;
				end
			end
			send_with_gap(directed[i].v);
		end
		vertex_valid <= 1'b0;
		wait_idle();

		// Register settings, extremes among them; each phase streams random vertices.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(vpp_pkg::REG_ROT_COS, 16'h0000);
					write_reg(vpp_pkg::REG_ROT_SIN, 16'h4000);
				end
				2: begin
					write_reg(vpp_pkg::REG_ROT_COS, 16'hC000);
					write_reg(vpp_pkg::REG_ROT_SIN, 16'hC000);
					write_reg(vpp_pkg::REG_TRANS_X, 16'h7FFF);
					write_reg(vpp_pkg::REG_PROJ_SCALE, 16'hFFFF);
				end
				3: begin
					write_reg(vpp_pkg::REG_ROT_COS, 16'h2D41);
					write_reg(vpp_pkg::REG_ROT_SIN, 16'hD2BF);
					write_reg(vpp_pkg::REG_TRANS_X, 16'h8000);
					write_reg(vpp_pkg::REG_TRANS_Y, 16'h7FFF);
					write_reg(vpp_pkg::REG_TRANS_Z, 16'h8000);
					write_reg(vpp_pkg::REG_PROJ_SCALE, 16'h0000);
				end
				4: begin
					write_reg(vpp_pkg::REG_TRANS_Y, 16'h8000);
					write_reg(vpp_pkg::REG_TRANS_Z, 16'h7FFF);
					write_reg(vpp_pkg::REG_PROJ_SCALE, 16'h2000);
				end
				5: begin
					// Values beyond the stated range, and an index past the list.
					write_reg(vpp_pkg::REG_ROT_COS, 16'h7FFF);
					write_reg(vpp_pkg::REG_ROT_SIN, 16'h8000);
					write_reg(REG_PAST_END_HI, 16'h1234);
					write_reg(REG_PAST_END, 16'hFFFF);
					write_reg(vpp_pkg::REG_TRANS_X, 16'($urandom));
					write_reg(vpp_pkg::REG_TRANS_Y, 16'hF000);
					write_reg(vpp_pkg::REG_TRANS_Z, 16'hF000);
					write_reg(vpp_pkg::REG_PROJ_SCALE, 16'h1800);
				end
				default: begin
					write_reg(vpp_pkg::REG_ROT_COS, vpp_pkg::ROT_COS_RST);
					write_reg(vpp_pkg::REG_ROT_SIN, vpp_pkg::ROT_SIN_RST);
					write_reg(vpp_pkg::REG_TRANS_X, vpp_pkg::TRANS_X_RST);
					write_reg(vpp_pkg::REG_TRANS_Y, vpp_pkg::TRANS_Y_RST);
					write_reg(vpp_pkg::REG_TRANS_Z, vpp_pkg::TRANS_Z_RST);
					write_reg(vpp_pkg::REG_PROJ_SCALE, vpp_pkg::PROJ_SCALE_RST);
				end
			endcase
			n = (ph == 0 || ph == 6) ? 400 : N_RANDOM / 7 - 50;
			for (int i = 0; i < n; i++) begin
				// Once per phase the output is held off while vertices keep coming.
				if (i == 40)
					hold_off_req = 1'b1;
				if (i >= 40 && i < 100)
					send_vertex(random_vertex());
				else
					send_with_gap(random_vertex());
			end
			vertex_valid <= 1'b0;
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/vpp_pkg.sv
rtl/vpp_front.sv
rtl/vpp_div_cell.sv
rtl/vertex_perspective_project.sv
rtl/vpp_check.sv
verif/testbench.sv
